FILE: src/utf8vc_pkg.sv
// Shared types and constants for the UTF-8 validator and counter.
package utf8vc_pkg;

	// Counter width default and width of the reported count fields
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned FIELD_WIDTH     = 32;

	// Width of a per-byte increment (code point length 1..4)
	localparam int unsigned LEN_WIDTH = 3;

	// Byte class boundaries
	localparam logic [7:0] ASCII_MAX     = 8'h7F;
	localparam logic [7:0] BAD_LEAD_MAX  = 8'hC1;
	localparam logic [7:0] LEAD2_MAX     = 8'hDF;
	localparam logic [7:0] LEAD3_MAX     = 8'hEF;
	localparam logic [7:0] LEAD4_MAX     = 8'hF4;
	localparam logic [7:0] LEAD3_LOW     = 8'hE0;
	localparam logic [7:0] LEAD3_SURR    = 8'hED;
	localparam logic [7:0] LEAD4_LOW     = 8'hF0;
	localparam logic [7:0] LEAD4_HIGH    = 8'hF4;
	localparam logic [7:0] CONT_MIN_A0   = 8'hA0;
	localparam logic [7:0] CONT_MAX_9F   = 8'h9F;
	localparam logic [7:0] CONT_MIN_90   = 8'h90;
	localparam logic [7:0] CONT_MAX_8F   = 8'h8F;
	localparam logic [7:0] CONT_TAG_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG      = 8'h80;

	// Sequence lengths
	localparam logic [LEN_WIDTH-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_WIDTH-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_WIDTH-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_WIDTH-1:0] LEN_4 = 3'd4;

	// Extra bound on the byte after a lead byte
	typedef enum logic [2:0] {
		RULE_NONE   = 3'd0,
		RULE_MIN_A0 = 3'd1,
		RULE_MAX_9F = 3'd2,
		RULE_MIN_90 = 3'd3,
		RULE_MAX_8F = 3'd4
	} rule_t;

	// Decoder state carried from byte to byte
	typedef struct packed {
		logic [1:0]           expected;
		logic [LEN_WIDTH-1:0] seq_len;
		rule_t                rule;
		logic                 err;
	} dec_state_t;

	// Completion of a code point by the current byte
	typedef struct packed {
		logic                 done;
		logic [LEN_WIDTH-1:0] len;
		logic                 wide;
	} dec_event_t;

endpackage

FILE: src/utf8vc_decode.sv
// Per-byte strict UTF-8 decoder: next state and code point completion.
module utf8vc_decode (
	input  utf8vc_pkg::dec_state_t st,
	input  logic [7:0]             data_byte,
	input  logic                   byte_present,
	output utf8vc_pkg::dec_state_t st_next,
	output utf8vc_pkg::dec_event_t ev
);
	import utf8vc_pkg::*;

	logic cont_ok;

	// Check a continuation byte against its tag and the second-byte bound
	always_comb begin
		cont_ok = (data_byte & CONT_TAG_MASK) == CONT_TAG;
		case (st.rule)
			RULE_MIN_A0: cont_ok = cont_ok && (data_byte >= CONT_MIN_A0);
			RULE_MAX_9F: cont_ok = cont_ok && (data_byte <= CONT_MAX_9F);
			RULE_MIN_90: cont_ok = cont_ok && (data_byte >= CONT_MIN_90);
			RULE_MAX_8F: cont_ok = cont_ok && (data_byte <= CONT_MAX_8F);
			default:     cont_ok = cont_ok;
		endcase
	end

	// Advance the decoder by one byte; ignore bytes after an error
	always_comb begin
		st_next = st;
		ev      = '0;
		if (byte_present && !st.err) begin
			if (st.expected == 2'd0) begin
				if (data_byte <= ASCII_MAX) begin
					ev.done = 1'b1;
					ev.len  = LEN_1;
				end else if (data_byte <= BAD_LEAD_MAX) begin
					st_next.err = 1'b1;
				end else if (data_byte <= LEAD2_MAX) begin
					st_next.seq_len  = LEN_2;
					st_next.expected = 2'd1;
					st_next.rule     = RULE_NONE;
				end else if (data_byte <= LEAD3_MAX) begin
					st_next.seq_len  = LEN_3;
					st_next.expected = 2'd2;
					st_next.rule     = (data_byte == LEAD3_LOW)  ? RULE_MIN_A0 :
					                   (data_byte == LEAD3_SURR) ? RULE_MAX_9F : RULE_NONE;
				end else if (data_byte <= LEAD4_MAX) begin
					st_next.seq_len  = LEN_4;
					st_next.expected = 2'd3;
					st_next.rule     = (data_byte == LEAD4_LOW)  ? RULE_MIN_90 :
					                   (data_byte == LEAD4_HIGH) ? RULE_MAX_8F : RULE_NONE;
				end else begin
					st_next.err = 1'b1;
				end
			end else begin
				st_next.rule = RULE_NONE;
				if (!cont_ok) begin
					st_next.err = 1'b1;
				end else begin
					st_next.expected = st.expected - 2'd1;
					if (st.expected == 2'd1) begin
						ev.done = 1'b1;
						ev.len  = st.seq_len;
						ev.wide = st.seq_len > LEN_1;
					end
				end
			end
		end
	end

endmodule

FILE: src/utf8vc_sat_count.sv
// Saturating counter with synchronous clear, exposing its next value.
module utf8vc_sat_count #(
	parameter int unsigned COUNT_WIDTH = utf8vc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              clear,
	input  logic [utf8vc_pkg::LEN_WIDTH-1:0]  add,
	output logic [COUNT_WIDTH-1:0]            count_next
);
	import utf8vc_pkg::*;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH:0]   sum;

	// Add and clamp at all ones
	always_comb begin
		sum        = {1'b0, count_q} + (COUNT_WIDTH+1)'(add);
		count_next = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	end

	// Update on each transfer; clear at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= clear ? '0 : count_next;
		end
	end

endmodule

FILE: src/utf8_validate_count.sv
// Top level of the strict UTF-8 validator and code point counter.
//
// Usage: a string is fed one byte per transfer on the item channel
// (item_valid / item_stall, fields data_byte, byte_present, last). An item
// with byte_present low carries no byte; with last high it closes the string
// without adding a byte. Each item marked last yields one transfer on the result channel
// (result_valid / result_stall): string_ok and the three saturating counts
// up to the first error. Other items yield no result.
// Throughput: one item per cycle while item_stall is low. An item accepted
// sits in the input register, is decoded there against the byte state and,
// if last, its result is loaded into the result register when it leaves
// the input register. The decode loop through the state registers sets
// this rate.
// Reset clears the decoder state, the counters and both valid flags.
// Stall: while the result register holds an untaken result, non-last items
// keep flowing; a last item waits in the input register and item_stall
// rises until the result is taken.
module utf8_validate_count #(
	parameter int unsigned COUNT_WIDTH = utf8vc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               byte_present,
	input  logic                               last,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               string_ok,
	output logic [utf8vc_pkg::FIELD_WIDTH-1:0] parsed_bytes,
	output logic [utf8vc_pkg::FIELD_WIDTH-1:0] code_points,
	output logic [utf8vc_pkg::FIELD_WIDTH-1:0] wide_code_points
);
	import utf8vc_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             present_s1;
	logic             last_s1;
	logic             out_free;
	logic             go_s1;
	logic             load_s1;
	dec_state_t       st_q;
	dec_state_t       st_next;
	dec_event_t       ev;
	logic [COUNT_WIDTH-1:0] bytes_next;
	logic [COUNT_WIDTH-1:0] points_next;
	logic [COUNT_WIDTH-1:0] wide_next;
	logic [FIELD_WIDTH-1:0] bytes_clip;
	logic [FIELD_WIDTH-1:0] points_clip;
	logic [FIELD_WIDTH-1:0] wide_clip;
	logic             result_valid_q;
	logic             string_ok_q;
	logic [FIELD_WIDTH-1:0] parsed_bytes_q;
	logic [FIELD_WIDTH-1:0] code_points_q;
	logic [FIELD_WIDTH-1:0] wide_code_points_q;

	// Handshake: a last item needs a free result register
	assign out_free   = !result_valid_q || !result_stall;
	assign go_s1      = valid_s1 && (!last_s1 || out_free);
	assign item_stall = valid_s1 && !go_s1;
	assign load_s1    = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || go_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1    <= data_byte;
			present_s1 <= byte_present;
			last_s1    <= last;
		end
	end

	// Decode one byte against the held state
	utf8vc_decode u_decode (
		.st           (st_q),
		.data_byte    (byte_s1),
		.byte_present (present_s1),
		.st_next      (st_next),
		.ev           (ev)
	);

	// Hold decoder state; clear it after the last item of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{expected: 2'd0, seq_len: '0, rule: RULE_NONE, err: 1'b0};
		end else if (go_s1) begin
			st_q <= last_s1 ? dec_state_t'{expected: 2'd0, seq_len: '0, rule: RULE_NONE,
			                               err: 1'b0}
			                : st_next;
		end
	end

	// Counters
	utf8vc_sat_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_bytes (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (go_s1),
		.clear      (last_s1),
		.add        (ev.done ? ev.len : '0),
		.count_next (bytes_next)
	);

	utf8vc_sat_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_points (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (go_s1),
		.clear      (last_s1),
		.add        (ev.done ? LEN_1 : '0),
		.count_next (points_next)
	);

	utf8vc_sat_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_wide (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (go_s1),
		.clear      (last_s1),
		.add        ((ev.done && ev.wide) ? LEN_1 : '0),
		.count_next (wide_next)
	);

	// Clamp counts to the report width, or zero-extend them if narrower
	generate
		if (COUNT_WIDTH > FIELD_WIDTH) begin : g_clip
			assign bytes_clip  = (|bytes_next[COUNT_WIDTH-1:FIELD_WIDTH])  ? '1
			                     : bytes_next[FIELD_WIDTH-1:0];
			assign points_clip = (|points_next[COUNT_WIDTH-1:FIELD_WIDTH]) ? '1
			                     : points_next[FIELD_WIDTH-1:0];
			assign wide_clip   = (|wide_next[COUNT_WIDTH-1:FIELD_WIDTH])   ? '1
			                     : wide_next[FIELD_WIDTH-1:0];
		end else begin : g_extend
			assign bytes_clip  = FIELD_WIDTH'(bytes_next);
			assign points_clip = FIELD_WIDTH'(points_next);
			assign wide_clip   = FIELD_WIDTH'(wide_next);
		end
	endgenerate

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			string_ok_q        <= !st_next.err && (st_next.expected == 2'd0);
			parsed_bytes_q     <= bytes_clip;
			code_points_q      <= points_clip;
			wide_code_points_q <= wide_clip;
		end
	end

	assign result_valid     = result_valid_q;
	assign string_ok        = string_ok_q;
	assign parsed_bytes     = parsed_bytes_q;
	assign code_points      = code_points_q;
	assign wide_code_points = wide_code_points_q;

	// Stall only with an item held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item stall without a held item");

	// State is clear after the last item of a string
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && last_s1) |=> (st_q.expected == 2'd0 && !st_q.err))
		else $error("decoder state not cleared after last item");

	// Count ordering of a reported result
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (wide_code_points_q <= code_points_q &&
		                    code_points_q <= parsed_bytes_q))
		else $error("result counts out of order");

endmodule

FILE: tb/utf8vc_tb_pkg.sv
// Expected-result tracking for the UTF-8 validator and counter testbench.
package utf8vc_tb_pkg;

	import utf8vc_pkg::*;

	// One string verdict as it leaves the block
	typedef struct packed {
		logic                   ok;
		logic [FIELD_WIDTH-1:0] nbytes;
		logic [FIELD_WIDTH-1:0] npoints;
		logic [FIELD_WIDTH-1:0] nwide;
	} verdict_t;

	class utf8_verdict_board;

		// Decoder state of the string in flight
		logic [1:0]             still_needed;
		logic [LEN_WIDTH-1:0]   open_len;
		rule_t                  rule;
		bit                     err_seen;
		logic [FIELD_WIDTH-1:0] byte_cnt;
		logic [FIELD_WIDTH-1:0] point_cnt;
		logic [FIELD_WIDTH-1:0] wide_cnt;

		verdict_t    pending_verdicts[$];
		int unsigned mismatches;

		function new();
			clear_string();
			mismatches = 0;
		endfunction

		function void clear_string();
			still_needed = '0;
			open_len     = '0;
			rule         = RULE_NONE;
			err_seen     = 1'b0;
			byte_cnt     = '0;
			point_cnt    = '0;
			wide_cnt     = '0;
		endfunction

		// Add with saturation at the all-ones value
		function logic [FIELD_WIDTH-1:0] sat_add(logic [FIELD_WIDTH-1:0] a,
				logic [LEN_WIDTH-1:0] n);
			logic [FIELD_WIDTH:0] sum;
			sum = {1'b0, a} + n;
			return sum[FIELD_WIDTH] ? '1 : sum[FIELD_WIDTH-1:0];
		endfunction

		function void close_point(logic [LEN_WIDTH-1:0] len);
			byte_cnt  = sat_add(byte_cnt, len);
			point_cnt = sat_add(point_cnt, LEN_1);
			if (len > LEN_1)
				wide_cnt = sat_add(wide_cnt, LEN_1);
		endfunction

		function void open_point(logic [LEN_WIDTH-1:0] len, rule_t bound);
			open_len     = len;
			still_needed = 2'(len - 1);
			rule         = bound;
		endfunction

		function void decode_octet(logic [7:0] b);
			bit ok;
			// Lead byte: classify and open a sequence
			if (still_needed == 0) begin
				if (b <= ASCII_MAX)
					close_point(LEN_1);
				else if (b <= BAD_LEAD_MAX)
					err_seen = 1'b1;
				else if (b <= LEAD2_MAX)
					open_point(LEN_2, RULE_NONE);
				else if (b <= LEAD3_MAX)
					open_point(LEN_3, b == LEAD3_LOW ? RULE_MIN_A0 :
						(b == LEAD3_SURR ? RULE_MAX_9F : RULE_NONE));
				else if (b <= LEAD4_MAX)
					open_point(LEN_4, b == LEAD4_LOW ? RULE_MIN_90 :
						(b == LEAD4_HIGH ? RULE_MAX_8F : RULE_NONE));
				else
					err_seen = 1'b1;
				return;
			end
			// Continuation byte: tag check plus any bound left by the lead
			ok = (b & CONT_TAG_MASK) == CONT_TAG;
			case (rule)
				RULE_MIN_A0: ok = ok && (b >= CONT_MIN_A0);
				RULE_MAX_9F: ok = ok && (b <= CONT_MAX_9F);
				RULE_MIN_90: ok = ok && (b >= CONT_MIN_90);
				RULE_MAX_8F: ok = ok && (b <= CONT_MAX_8F);
				default: ;
			endcase
			rule = RULE_NONE;
			if (!ok) begin
				err_seen = 1'b1;
				return;
			end
			still_needed = still_needed - 2'd1;
			if (still_needed == 0)
				close_point(open_len);
		endfunction

		// Note an accepted input transfer
		function void note_item(logic [7:0] b, logic present, logic lst);
			verdict_t v;
			if (present && !err_seen)
				decode_octet(b);
			if (lst) begin
				v.ok      = !err_seen && still_needed == 0;
				v.nbytes  = byte_cnt;
				v.npoints = point_cnt;
				v.nwide   = wide_cnt;
				pending_verdicts.push_back(v);
				clear_string();
			end
		endfunction

		// Compare a result transfer with the oldest expected verdict
		function void check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: valid=%0b bytes=%0d points=%0d wide=%0d",
						got.ok, got.nbytes, got.npoints, got.nwide);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.ok !== want.ok || got.nbytes !== want.nbytes ||
					got.npoints !== want.npoints || got.nwide !== want.nwide) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: valid %0b/%0b bytes %0d/%0d points %0d/%0d wide %0d/%0d",
						want.ok, got.ok, want.nbytes, got.nbytes,
						want.npoints, got.npoints, want.nwide, got.nwide);
			end
		endfunction

		function int unsigned outstanding();
			return pending_verdicts.size();
		endfunction

	endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for the UTF-8 validator and counter.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import utf8vc_pkg::*;
	import utf8vc_tb_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned QUIET_LIMIT  = 500;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [7:0]  CONT_TOP     = 8'hBF;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	logic [7:0]             data_byte    = '0;
	logic                   byte_present = 1'b0;
	logic                   last         = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic                   string_ok;
	logic [FIELD_WIDTH-1:0] parsed_bytes;
	logic [FIELD_WIDTH-1:0] code_points;
	logic [FIELD_WIDTH-1:0] wide_code_points;

	utf8_verdict_board board;
	logic [7:0]        text[$];
	bit                calm         = 1'b0;
	int unsigned       items_sent   = 0;
	int unsigned       quiet_cycles = 0;

	utf8_validate_count u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.data_byte        (data_byte),
		.byte_present     (byte_present),
		.last             (last),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.string_ok        (string_ok),
		.parsed_bytes     (parsed_bytes),
		.code_points      (code_points),
		.wide_code_points (wide_code_points)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one item after a random gap, hold it until the transfer
	task automatic send_item(input logic [7:0] b, input logic present, input logic lst);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid   <= 1'b1;
		data_byte    <= b;
		byte_present <= present;
		last         <= lst;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Send the bytes in text as one string, closed on its last byte or by a bare marker
	task automatic send_text(input bit marker_close, input bit sprinkle);
		for (int i = 0; i < text.size(); i++) begin
			if (sprinkle && $urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(text[i], 1'b1, !marker_close && i == text.size() - 1);
		end
		if (marker_close || text.size() == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
		return 8'($urandom_range(lo, hi));
	endfunction

	// Append one well-formed code point with random content
	function automatic void add_point();
		logic [7:0] lead;
		case ($urandom_range(0, 3))
			0: text.push_back(pick(8'h00, ASCII_MAX));
			1: begin
				text.push_back(pick(BAD_LEAD_MAX + 8'd1, LEAD2_MAX));
				text.push_back(pick(CONT_TAG, CONT_TOP));
			end
			2: begin
				case ($urandom_range(0, 2))
					0: lead = LEAD3_LOW;
					1: lead = LEAD3_SURR;
					default: lead = pick(LEAD3_LOW, LEAD3_MAX);
				endcase
				text.push_back(lead);
				if (lead == LEAD3_LOW)
					text.push_back(pick(CONT_MIN_A0, CONT_TOP));
				else if (lead == LEAD3_SURR)
					text.push_back(pick(CONT_TAG, CONT_MAX_9F));
				else
					text.push_back(pick(CONT_TAG, CONT_TOP));
				text.push_back(pick(CONT_TAG, CONT_TOP));
			end
			default: begin
				case ($urandom_range(0, 2))
					0: lead = LEAD4_LOW;
					1: lead = LEAD4_HIGH;
					default: lead = pick(LEAD4_LOW, LEAD4_HIGH);
				endcase
				text.push_back(lead);
				if (lead == LEAD4_LOW)
					text.push_back(pick(CONT_MIN_90, CONT_TOP));
				else if (lead == LEAD4_HIGH)
					text.push_back(pick(CONT_TAG, CONT_MAX_8F));
				else
					text.push_back(pick(CONT_TAG, CONT_TOP));
				text.push_back(pick(CONT_TAG, CONT_TOP));
				text.push_back(pick(CONT_TAG, CONT_TOP));
			end
		endcase
	endfunction

	// Build a random string: mostly well-formed, some corrupted, clipped or pure noise
	function automatic void build_text();
		int unsigned shape;
		text.delete();
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 10)) add_point();
			if (shape == 1 && text.size() != 0)
				text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
			else if (shape == 2 && text.size() != 0)
				void'(text.pop_back());
		end
	endfunction

	// Result side: stall some results at random before taking them
	initial begin : result_side
		int unsigned hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			result_stall <= (hold != 0);
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			if (hold != 0) begin
				repeat (hold - 1) @(posedge clk);
				@(negedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end
			@(negedge clk);
		end
	end

	// Monitor both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				board.note_item(data_byte, byte_present, last);
			if (result_valid && !result_stall)
				board.check_verdict({string_ok, parsed_bytes, code_points, wide_code_points});
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Abort if nothing transfers for too long
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_start;
		bit          marker_close;
		board = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty string, then a bare no-byte item inside a string
		send_item(8'($urandom), 1'b0, 1'b1);
		send_item(8'($urandom), 1'b0, 1'b0);
		// ASCII extremes, smallest two-byte form, smallest three-byte form
		text = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'h7F};
		send_text(1'b0, 1'b0);
		// Highest code point below the surrogates, highest code point overall
		text = '{8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text(1'b0, 1'b0);
		// Overlong three-byte, surrogate, overlong four-byte, above U+10FFFF
		text = '{8'hE0, 8'h9F};
		send_text(1'b0, 1'b0);
		text = '{8'hED, 8'hA0};
		send_text(1'b0, 1'b0);
		text = '{8'hF0, 8'h8F};
		send_text(1'b0, 1'b0);
		text = '{8'hF4, 8'h90};
		send_text(1'b0, 1'b0);
		// Bare continuation and top invalid lead
		text = '{8'h80};
		send_text(1'b0, 1'b0);
		text = '{8'hFF};
		send_text(1'b0, 1'b0);
		// Sequence clipped by the end marker
		text = '{8'hF0, 8'h90, 8'h80};
		send_text(1'b1, 1'b0);

		// Random strings, with idle-free stretches now and then
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			build_text();
			marker_close = ($urandom_range(0, 3) == 0);
			send_text(marker_close, 1'b1);
		end
		item_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
